>>> rtl/cet_pkg.sv
// Shared token codes, character constants and keyword table for the expression tokenizer.
package cet_pkg;

   // Token kinds
   localparam logic [4:0] TK_END    = 5'd0;
   localparam logic [4:0] TK_ERR    = 5'd1;
   localparam logic [4:0] TK_NUM    = 5'd2;
   localparam logic [4:0] TK_EQ     = 5'd3;
   localparam logic [4:0] TK_PLUS   = 5'd4;
   localparam logic [4:0] TK_MIN    = 5'd5;
   localparam logic [4:0] TK_MULT   = 5'd6;
   localparam logic [4:0] TK_DIV    = 5'd7;
   localparam logic [4:0] TK_EXP    = 5'd8;
   localparam logic [4:0] TK_LPAREN = 5'd9;
   localparam logic [4:0] TK_RPAREN = 5'd10;
   localparam logic [4:0] TK_MOD    = 5'd11;
   localparam logic [4:0] TK_SIN    = 5'd12;
   localparam logic [4:0] TK_COS    = 5'd13;
   localparam logic [4:0] TK_TAN    = 5'd14;
   localparam logic [4:0] TK_CSC    = 5'd15;
   localparam logic [4:0] TK_SEC    = 5'd16;
   localparam logic [4:0] TK_COT    = 5'd17;
   localparam logic [4:0] TK_ASIN   = 5'd18;
   localparam logic [4:0] TK_ACOS   = 5'd19;
   localparam logic [4:0] TK_ATAN   = 5'd20;
   localparam logic [4:0] TK_SINH   = 5'd21;
   localparam logic [4:0] TK_COSH   = 5'd22;
   localparam logic [4:0] TK_TANH   = 5'd23;
   localparam logic [4:0] TK_PI     = 5'd24;
   localparam logic [4:0] TK_E      = 5'd25;
   localparam logic [4:0] TK_ABS    = 5'd26;
   localparam logic [4:0] TK_SQRT   = 5'd27;
   localparam logic [4:0] TK_LOG    = 5'd28;
   localparam logic [4:0] TK_LN     = 5'd29;
   localparam logic [4:0] TK_ANS    = 5'd30;

   // Error causes
   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_POINT   = 2'd1;
   localparam logic [1:0] CAUSE_KEYWORD = 2'd2;
   localparam logic [1:0] CAUSE_ILLEGAL = 2'd3;

   // Characters
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_CARET  = "^";
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_PCT    = "%";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_ZERO   = "0";
   localparam logic [7:0] CH_NINE   = "9";
   localparam logic [7:0] CH_UP_A   = "A";
   localparam logic [7:0] CH_UP_Z   = "Z";
   localparam logic [7:0] CH_LO_A   = "a";
   localparam logic [7:0] CH_LO_Z   = "z";

   // Result buffer
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Keywords: up to four letters, five bits a letter (A=1..Z=26), first letter highest
   localparam int KW_COUNT = 20;
   localparam int KW_BITS  = 20;

   function automatic logic [KW_BITS-1:0] kw_code(input logic [31:0] text);
      logic [KW_BITS-1:0] acc;
      logic [7:0]         ch;
      acc = '0;
      for (int i = 3; i >= 0; i--) begin
         ch = text[8*i +: 8];
         if (ch != 8'd0) begin
            acc = {acc[KW_BITS-6:0], ch[4:0]};
         end
      end
      return acc;
   endfunction

   function automatic logic [2:0] kw_len(input logic [31:0] text);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (text[8*i +: 8] != 8'd0) begin
            n = n + 3'd1;
         end
      end
      return n;
   endfunction

   localparam logic [31:0] KW_TEXT [KW_COUNT] = '{
      "SIN", "COS", "TAN", "CSC", "SEC", "COT", "ASIN", "ACOS", "ATAN", "SINH",
      "COSH", "TANH", "PI", "E", "ABS", "SQRT", "LOG", "LN", "MOD", "ANS"
   };

   localparam logic [4:0] KW_KIND [KW_COUNT] = '{
      TK_SIN, TK_COS, TK_TAN, TK_CSC, TK_SEC, TK_COT, TK_ASIN, TK_ACOS, TK_ATAN,
      TK_SINH, TK_COSH, TK_TANH, TK_PI, TK_E, TK_ABS, TK_SQRT, TK_LOG, TK_LN,
      TK_MOD, TK_ANS
   };

   // Operator symbol to token kind; TK_END when not a symbol
   function automatic logic [4:0] symbol_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         CH_EQUAL:  k = TK_EQ;
         CH_PLUS:   k = TK_PLUS;
         CH_MINUS:  k = TK_MIN;
         CH_STAR:   k = TK_MULT;
         CH_SLASH:  k = TK_DIV;
         CH_CARET:  k = TK_EXP;
         CH_LPAREN: k = TK_LPAREN;
         CH_RPAREN: k = TK_RPAREN;
         CH_PCT:    k = TK_MOD;
         default:   k = TK_END;
      endcase
      return k;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
   endfunction

endpackage

>>> rtl/calculator_expression_tokenizer.sv
// Expression tokenizer: characters in, NUM, operator, keyword, error and END tokens out.
//
// Takes one character per request and returns tokens in order, each character passing
// through the input register and then the result buffer. A character that ends a number
// or a known keyword and is itself a token gives two results, as does an end of text that
// ends a number or a word; these leave one per cycle through a four-entry result buffer,
// and the request side stalls only when fewer than two buffer entries are free. Apart from
// those stalls the block sustains one character per cycle. The mantissa saturates at
// 2^MANTISSA_BITS-1; words longer than MAX_KEYWORD_LEN letters are unknown keywords.
// After an error all characters up to the end-of-text request (req_tlast) are dropped.
module calculator_expression_tokenizer #(
   parameter int MANTISSA_BITS   = 64,
   parameter int MAX_KEYWORD_LEN = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request side
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [7:0]                               req_tdata,  // char_code
   input  logic                                     req_tlast,  // end_of_text
   // result side
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // mantissa, fraction_digits[4:0], mantissa_overflow, error_cause[1:0], zero fill
   output logic [((MANTISSA_BITS + 8 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [4:0]                               rsp_tuser,  // token_kind
   output logic                                     rsp_tlast   // last_of_run
);
   import cet_pkg::*;

   localparam int DATA_W = ((MANTISSA_BITS + 8 + 7) / 8) * 8;
   localparam int LET_W  = 5 * MAX_KEYWORD_LEN;
   localparam int WLEN_W = $clog2(MAX_KEYWORD_LEN + 2);
   localparam int WIDE_W = MANTISSA_BITS + 4;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_WORD,
      MODE_ERROR
   } mode_type;

   typedef struct packed {
      logic [4:0]               kind;
      logic [MANTISSA_BITS-1:0] mant;
      logic [4:0]               frac;
      logic                     ovf;
      logic [1:0]               cause;
      logic                     last;
   } token_type;

   localparam token_type TOK_ZERO = '0;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_eot_ff;

   // scanner state
   mode_type                 mode_ff,  mode_in;
   logic [MANTISSA_BITS-1:0] accum_ff, accum_in;
   logic [4:0]               frac_ff,  frac_in;
   logic                     point_ff, point_in;
   logic                     sat_ff,   sat_in;
   logic [LET_W-1:0]         letters_ff, letters_in;
   logic [WLEN_W-1:0]        wlen_ff,  wlen_in;

   // result buffer
   token_type           fifo_mem [FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff,  count_in;

   logic       fire;
   logic       pop;
   logic [1:0] push_n;
   token_type  ent0, ent1;

   assign fire       = in_valid_ff && (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign req_tready = !in_valid_ff || fire;
   assign pop        = rsp_tvalid && rsp_tready;

   // Character classes
   logic       c_space, c_digit, c_alpha, c_dot;
   logic [4:0] c_sym;
   assign c_space = is_space(in_char_ff);
   assign c_digit = is_digit(in_char_ff);
   assign c_alpha = is_alpha(in_char_ff);
   assign c_dot   = (in_char_ff == CH_DOT);
   assign c_sym   = symbol_kind(in_char_ff);

   // Fresh-start handling of a character, from cleared state
   mode_type                 st_mode;
   logic [MANTISSA_BITS-1:0] st_accum;
   logic                     st_point;
   logic [LET_W-1:0]         st_letters;
   logic [WLEN_W-1:0]        st_wlen;
   logic                     st_tv;
   token_type                st_tok;

   always_comb begin
      st_mode    = MODE_IDLE;
      st_accum   = '0;
      st_point   = 1'b0;
      st_letters = '0;
      st_wlen    = '0;
      st_tv      = 1'b0;
      st_tok     = TOK_ZERO;
      if (c_space) begin
         st_mode = MODE_IDLE;
      end else if (c_sym != TK_END) begin
         st_tv       = 1'b1;
         st_tok.kind = c_sym;
      end else if (c_dot) begin
         st_mode  = MODE_NUMBER;
         st_point = 1'b1;
      end else if (c_digit) begin
         st_mode  = MODE_NUMBER;
         st_accum = MANTISSA_BITS'(in_char_ff[3:0]);
      end else if (c_alpha) begin
         st_mode    = MODE_WORD;
         st_letters = LET_W'(in_char_ff[4:0]);
         st_wlen    = WLEN_W'(1);
      end else begin
         st_mode      = MODE_ERROR;
         st_tv        = 1'b1;
         st_tok.kind  = TK_ERR;
         st_tok.cause = CAUSE_ILLEGAL;
      end
   end

   // Next decimal digit: accum * 10 + d, saturating
   logic [WIDE_W-1:0] wide;
   logic              wide_over;
   assign wide = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
               + {{MANTISSA_BITS{1'b0}}, in_char_ff[3:0]};
   assign wide_over = (wide[WIDE_W-1:MANTISSA_BITS] != 4'd0);

   // Keyword match on the collected letters
   logic       kw_hit;
   logic [4:0] kw_kind_hit;
   always_comb begin
      kw_hit      = 1'b0;
      kw_kind_hit = TK_END;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (wlen_ff == WLEN_W'(kw_len(KW_TEXT[i]))
             && letters_ff == LET_W'(kw_code(KW_TEXT[i]))) begin
            kw_hit      = 1'b1;
            kw_kind_hit = KW_KIND[i];
         end
      end
   end

   token_type num_tok, word_tok;
   always_comb begin
      num_tok      = TOK_ZERO;
      num_tok.kind = TK_NUM;
      num_tok.mant = accum_ff;
      num_tok.frac = frac_ff;
      num_tok.ovf  = sat_ff;
      word_tok     = TOK_ZERO;
      if (kw_hit) begin
         word_tok.kind = kw_kind_hit;
      end else begin
         word_tok.kind  = TK_ERR;
         word_tok.cause = CAUSE_KEYWORD;
      end
   end

   // Scanner: next state and up to two tokens (pending first, then second)
   logic      pv, sv;
   token_type p_tok, s_tok;

   always_comb begin
      mode_in    = mode_ff;
      accum_in   = accum_ff;
      frac_in    = frac_ff;
      point_in   = point_ff;
      sat_in     = sat_ff;
      letters_in = letters_ff;
      wlen_in    = wlen_ff;
      pv         = 1'b0;
      sv         = 1'b0;
      p_tok      = TOK_ZERO;
      s_tok      = TOK_ZERO;
      if (in_eot_ff) begin
         if (mode_ff == MODE_NUMBER) begin
            pv    = 1'b1;
            p_tok = num_tok;
         end else if (mode_ff == MODE_WORD) begin
            pv    = 1'b1;
            p_tok = word_tok;
         end
         sv         = 1'b1;
         s_tok.kind = TK_END;
         mode_in    = MODE_IDLE;
         accum_in   = '0;
         frac_in    = '0;
         point_in   = 1'b0;
         sat_in     = 1'b0;
         letters_in = '0;
         wlen_in    = '0;
      end else begin
         case (mode_ff)
            MODE_NUMBER: begin
               if (c_dot && point_ff) begin
                  sv          = 1'b1;
                  s_tok.kind  = TK_ERR;
                  s_tok.cause = CAUSE_POINT;
                  mode_in     = MODE_ERROR;
                  accum_in    = '0;
                  frac_in     = '0;
                  point_in    = 1'b0;
                  sat_in      = 1'b0;
               end else if (c_dot) begin
                  point_in = 1'b1;
               end else if (c_digit) begin
                  if (!sat_ff && !wide_over) begin
                     accum_in = wide[MANTISSA_BITS-1:0];
                  end else begin
                     accum_in = '1;
                     sat_in   = 1'b1;
                  end
                  if (point_ff && frac_ff != 5'd31) begin
                     frac_in = frac_ff + 5'd1;
                  end
               end else begin
                  pv         = 1'b1;
                  p_tok      = num_tok;
                  sv         = st_tv;
                  s_tok      = st_tok;
                  mode_in    = st_mode;
                  accum_in   = st_accum;
                  frac_in    = '0;
                  point_in   = st_point;
                  sat_in     = 1'b0;
                  letters_in = st_letters;
                  wlen_in    = st_wlen;
               end
            end
            MODE_WORD: begin
               if (c_alpha) begin
                  if (wlen_ff < WLEN_W'(MAX_KEYWORD_LEN)) begin
                     letters_in = {letters_ff[LET_W-6:0], in_char_ff[4:0]};
                     wlen_in    = wlen_ff + WLEN_W'(1);
                  end else begin
                     wlen_in = WLEN_W'(MAX_KEYWORD_LEN + 1);
                  end
               end else if (!kw_hit) begin
                  // unknown word; the ending character is dropped
                  pv         = 1'b1;
                  p_tok      = word_tok;
                  mode_in    = MODE_ERROR;
                  letters_in = '0;
                  wlen_in    = '0;
               end else begin
                  pv         = 1'b1;
                  p_tok      = word_tok;
                  sv         = st_tv;
                  s_tok      = st_tok;
                  mode_in    = st_mode;
                  accum_in   = st_accum;
                  frac_in    = '0;
                  point_in   = st_point;
                  sat_in     = 1'b0;
                  letters_in = st_letters;
                  wlen_in    = st_wlen;
               end
            end
            MODE_IDLE: begin
               sv         = st_tv;
               s_tok      = st_tok;
               mode_in    = st_mode;
               accum_in   = st_accum;
               frac_in    = '0;
               point_in   = st_point;
               sat_in     = 1'b0;
               letters_in = st_letters;
               wlen_in    = st_wlen;
            end
            default: begin
               mode_in = MODE_ERROR;
            end
         endcase
      end
   end

   // Compact the tokens and mark the final one
   always_comb begin
      push_n = fire ? ({1'b0, pv} + {1'b0, sv}) : 2'd0;
      ent0   = pv ? p_tok : s_tok;
      ent1   = s_tok;
      ent0.last = !(pv && sv);
      ent1.last = 1'b1;
   end

   // Buffer pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   // Control and scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         accum_ff    <= '0;
         frac_ff     <= '0;
         point_ff    <= 1'b0;
         sat_ff      <= 1'b0;
         letters_ff  <= '0;
         wlen_ff     <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            mode_ff    <= mode_in;
            accum_ff   <= accum_in;
            frac_ff    <= frac_in;
            point_ff   <= point_in;
            sat_ff     <= sat_in;
            letters_ff <= letters_in;
            wlen_ff    <= wlen_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Request payload register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   // Result buffer storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_mem[wr_ptr_ff] <= ent0;
      end
      if (push_n == 2'd2) begin
         fifo_mem[wr_ptr_ff + PTR_W'(1)] <= ent1;
      end
   end

   // Result side
   token_type head;
   assign head       = fifo_mem[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = DATA_W'({head.cause, head.ovf, head.frac, head.mant});
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result buffer count beyond depth");

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && !in_eot_ff && mode_ff == MODE_ERROR) |-> push_n == 2'd0)
      else $error("token produced while dropping input after an error");

   a_eot_token: assert property (@(posedge clock) disable iff (reset)
      (fire && in_eot_ff) |-> push_n != 2'd0)
      else $error("end of text produced no token");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && in_eot_ff) |=> (mode_ff == MODE_IDLE && accum_ff == '0 && wlen_ff == '0))
      else $error("scanner state not cleared after end of text");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> accum_ff == '1)
      else $error("saturated mantissa is not at its maximum");

endmodule
